// ===== hdl/box_avg_pkg.sv =====
package box_avg_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_CFG_BITS  = 3;
    localparam int WIDTH_CFG_BITS  = 14;
    localparam int CFG_DATA_BITS   = 14;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int OUTQ_DEPTH      = 3;
    localparam int OUTQ_PTR_BITS   = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_LOG2 = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_WIDTH = 1'b1;

    localparam logic [SCALE_CFG_BITS-1:0] SCALE_LOG2_RESET = 3'd1;
    localparam logic [WIDTH_CFG_BITS-1:0] FULL_WIDTH_RESET = 14'd8192;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_value;
        logic                          first_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] avg_value;
        logic                          end_of_row;
    } pixel_out_t;

    typedef struct packed {
        logic tile_end;
        logic first_row;
        logic emit;
        logic last;
    } tile_flags_t;

endpackage

// ===== hdl/box_avg_ctrl.sv =====
module box_avg_ctrl #(
    parameter int MAX_WIDTH      = 8192,
    parameter int MAX_SCALE_LOG2 = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [box_avg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [box_avg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 accept,
    input  box_avg_pkg::pixel_in_t               pixel,
    output logic [$clog2(MAX_SCALE_LOG2+1)-1:0]  shift,
    output logic [$clog2(MAX_WIDTH)-2:0]         addr,
    output box_avg_pkg::tile_flags_t             flags,
    output logic signed [box_avg_pkg::SAMPLE_BITS+2*MAX_SCALE_LOG2-1:0] row_sum
);
    import box_avg_pkg::*;

    localparam int SW   = $clog2(MAX_SCALE_LOG2 + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int AW   = CW - 1;
    localparam int RW   = MAX_SCALE_LOG2;
    localparam int XW   = CW + MAX_SCALE_LOG2;
    localparam int CMPW = $clog2(MAX_WIDTH + (2 ** MAX_SCALE_LOG2) + 1);
    localparam int WCW  = WIDTH_CFG_BITS + 1;
    localparam int SUMW = SAMPLE_BITS + 2 * MAX_SCALE_LOG2;

    logic [SCALE_CFG_BITS-1:0] scale_cfg_reg;
    logic [WIDTH_CFG_BITS-1:0] width_cfg_reg;
    logic [CW-1:0]             column_counter_reg, column_counter_next;
    logic [RW-1:0]             row_in_tile_reg, row_in_tile_next;
    logic signed [SUMW-1:0]    row_sum_reg, row_sum_next;

    logic [SW-1:0]             s_eff;
    logic [WCW-1:0]            width_wide;
    logic [CMPW-1:0]           width_eff;
    logic [CW-1:0]             cnt_start;
    logic [RW-1:0]             rit_start;
    logic [CW-1:0]             col;
    logic [RW-1:0]             mask_r;
    logic [RW-1:0]             rit;
    logic [XW-1:0]             mask_x;
    logic [XW-1:0]             dx;
    logic [CMPW-1:0]           scale_c;
    logic [CW-1:0]             col_shift;
    logic                      wrap;
    logic signed [SAMPLE_BITS-1:0] px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_cfg_reg <= SCALE_LOG2_RESET;
            width_cfg_reg <= FULL_WIDTH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SCALE_LOG2: scale_cfg_reg <= cfg_data[SCALE_CFG_BITS-1:0];
                REG_FULL_WIDTH: width_cfg_reg <= cfg_data[WIDTH_CFG_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (scale_cfg_reg > SCALE_CFG_BITS'(MAX_SCALE_LOG2))
            s_eff = SW'(MAX_SCALE_LOG2);
        else
            s_eff = scale_cfg_reg[SW-1:0];

        width_wide = {1'b0, width_cfg_reg};
        if (width_wide == '0)
            width_eff = CMPW'(1);
        else if (width_wide > WCW'(MAX_WIDTH))
            width_eff = CMPW'(MAX_WIDTH);
        else
            width_eff = width_wide[CMPW-1:0];

        px        = pixel.pixel_value;
        cnt_start = pixel.first_of_frame ? '0 : column_counter_reg;
        rit_start = pixel.first_of_frame ? '0 : row_in_tile_reg;
        col       = (CMPW'(cnt_start) >= width_eff) ? '0 : cnt_start;

        mask_r  = (RW'(1) << s_eff) - RW'(1);
        rit     = rit_start & mask_r;
        mask_x  = (XW'(1) << s_eff) - XW'(1);
        dx      = XW'(col) & mask_x;
        scale_c = CMPW'(1) << s_eff;

        flags.tile_end  = (dx == mask_x);
        flags.first_row = (rit == '0);
        flags.emit      = (dx == mask_x) && (rit == mask_r);
        flags.last      = (CMPW'(col) + CMPW'(1) + scale_c) > width_eff;

        col_shift = col >> s_eff;
        addr      = col_shift[AW-1:0];

        if (dx == '0)
            row_sum_next = SUMW'(px);
        else
            row_sum_next = row_sum_reg + SUMW'(px);

        wrap = (CMPW'(col) + CMPW'(1)) >= width_eff;
        if (wrap)
        begin
            column_counter_next = '0;
            row_in_tile_next    = (rit + RW'(1)) & mask_r;
        end
        else
        begin
            column_counter_next = col + CW'(1);
            row_in_tile_next    = rit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_counter_reg <= '0;
            row_in_tile_reg    <= '0;
            row_sum_reg        <= '0;
        end
        else if (accept)
        begin
            column_counter_reg <= column_counter_next;
            row_in_tile_reg    <= row_in_tile_next;
            row_sum_reg        <= row_sum_next;
        end
    end

    assign shift   = s_eff;
    assign row_sum = row_sum_reg;

endmodule

// ===== hdl/box_avg_colmem.sv =====
module box_avg_colmem #(
    parameter int MAX_WIDTH      = 8192,
    parameter int MAX_SCALE_LOG2 = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [$clog2(MAX_WIDTH)-2:0]         addr,
    input  box_avg_pkg::tile_flags_t             flags,
    input  logic [$clog2(MAX_SCALE_LOG2+1)-1:0]  shift,
    input  logic signed [box_avg_pkg::SAMPLE_BITS+2*MAX_SCALE_LOG2-1:0] row_sum,
    output logic                                 busy,
    output logic                                 push,
    output box_avg_pkg::pixel_out_t              result
);
    import box_avg_pkg::*;

    localparam int SW    = $clog2(MAX_SCALE_LOG2 + 1);
    localparam int AW    = $clog2(MAX_WIDTH) - 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int SUMW  = SAMPLE_BITS + 2 * MAX_SCALE_LOG2;

    logic signed [SUMW-1:0] col_mem [DEPTH];
    logic signed [SUMW-1:0] rd_data_reg;
    logic                   s1_valid_reg;
    tile_flags_t            s1_flags_reg;
    logic [AW-1:0]          s1_addr_reg;

    logic signed [SUMW-1:0] total;
    logic signed [SUMW-1:0] avg_full;
    logic [SW:0]            shamt;

    // same-column updates are at least two requests apart, so the read
    // issued at accept never races the write-back of the previous request
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= col_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_flags_reg.tile_end && (shift != '0))
            col_mem[s1_addr_reg] <= total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
            s1_addr_reg  <= addr;
        end
    end

    always_comb
    begin
        if (s1_flags_reg.first_row)
            total = row_sum;
        else
            total = rd_data_reg + row_sum;
        shamt             = {shift, 1'b0};
        avg_full          = total >>> shamt;
        result.avg_value  = avg_full[SAMPLE_BITS-1:0];
        result.end_of_row = s1_flags_reg.last;
    end

    assign push = s1_valid_reg && s1_flags_reg.emit;
    assign busy = s1_valid_reg;

endmodule

// ===== hdl/box_avg_outq.sv =====
module box_avg_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  box_avg_pkg::pixel_out_t push_data,
    input  logic                    stall,
    output logic                    valid,
    output box_avg_pkg::pixel_out_t data,
    output logic [box_avg_pkg::OUTQ_PTR_BITS-1:0] level
);
    import box_avg_pkg::*;

    pixel_out_t               entries [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_PTR_BITS-1:0] count_reg, count_next;
    logic                     pop;

    always_comb
    begin
        pop = (count_reg != '0) && !stall;

        wr_ptr_next = wr_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUTQ_PTR_BITS'(1);

        rd_ptr_next = rd_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUTQ_PTR_BITS'(1);

        count_next = count_reg + OUTQ_PTR_BITS'(push) - OUTQ_PTR_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    assign valid = (count_reg != '0);
    assign data  = entries[rd_ptr_reg];
    assign level = count_reg;

endmodule

// ===== hdl/box_average_downsampler.sv =====
// channel  | valid       | stall       | payload
// input    | pixel_valid | pixel_stall | pixel (pixel_in_t)
// output   | avg_valid   | avg_stall   | avg (pixel_out_t)
// config   | cfg_write_en| -           | cfg_index, cfg_data
//
// One request per cycle unless pixel_stall; results pass a stage register, then the queue.
// Column sums live in a one-port-read, one-port-write memory of MAX_WIDTH/2
// entries; at most one read-modify-write per request sets the rate.
// Reset clears counters and row sum; the sum memory is not cleared.
// pixel_stall rises only when the three-entry output queue may fill.
module box_average_downsampler #(
    parameter int MAX_WIDTH      = 8192,
    parameter int MAX_SCALE_LOG2 = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [box_avg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [box_avg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  box_avg_pkg::pixel_in_t                 pixel,
    output logic                                   avg_valid,
    input  logic                                   avg_stall,
    output box_avg_pkg::pixel_out_t                avg
);
    import box_avg_pkg::*;

    localparam int SW   = $clog2(MAX_SCALE_LOG2 + 1);
    localparam int AW   = $clog2(MAX_WIDTH) - 1;
    localparam int SUMW = SAMPLE_BITS + 2 * MAX_SCALE_LOG2;

    logic                     accept;
    logic [SW-1:0]            shift;
    logic [AW-1:0]            addr;
    tile_flags_t              flags;
    logic signed [SUMW-1:0]   row_sum;
    logic                     busy;
    logic                     push;
    pixel_out_t               result;
    logic [OUTQ_PTR_BITS-1:0] level;

    assign pixel_stall = (OUTQ_PTR_BITS'(level) + OUTQ_PTR_BITS'(busy))
                         >= OUTQ_PTR_BITS'(OUTQ_DEPTH);
    assign accept      = pixel_valid && !pixel_stall;

    box_avg_ctrl #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_SCALE_LOG2 (MAX_SCALE_LOG2)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .pixel        (pixel),
        .shift        (shift),
        .addr         (addr),
        .flags        (flags),
        .row_sum      (row_sum)
    );

    box_avg_colmem #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_SCALE_LOG2 (MAX_SCALE_LOG2)
    ) u_colmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .addr    (addr),
        .flags   (flags),
        .shift   (shift),
        .row_sum (row_sum),
        .busy    (busy),
        .push    (push),
        .result  (result)
    );

    box_avg_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .stall     (avg_stall),
        .valid     (avg_valid),
        .data      (avg),
        .level     (level)
    );

endmodule

// ===== dv/box_average_downsampler_test.sv =====
`timescale 1ns / 1ps

module box_average_downsampler_test;

    import box_avg_pkg::*;

    localparam int WIDTH_LIMIT   = 8192;
    localparam int SCALE_LIMIT   = 4;
    localparam int SUM_DEPTH     = WIDTH_LIMIT / 2;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int HOLD_CYCLES   = 400;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    class tile_average_scoreboard;
        logic [SCALE_CFG_BITS-1:0] scale_reg;
        logic [WIDTH_CFG_BITS-1:0] width_reg;
        longint                    column_totals[SUM_DEPTH];
        longint                    row_acc;
        int unsigned               col_pos;
        int unsigned               band_row;
        pixel_out_t                expected_avgs[$];
        int unsigned               mismatches;
        int unsigned               results_seen;
        int unsigned               requests_seen;

        function new();
            scale_reg     = SCALE_LOG2_RESET;
            width_reg     = FULL_WIDTH_RESET;
            row_acc       = 0;
            col_pos       = 0;
            band_row      = 0;
            mismatches    = 0;
            results_seen  = 0;
            requests_seen = 0;
            foreach (column_totals[i]) column_totals[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_avgs.size();
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_SCALE_LOG2)
                scale_reg = data[SCALE_CFG_BITS-1:0];
            else if (idx == REG_FULL_WIDTH)
                width_reg = data[WIDTH_CFG_BITS-1:0];
        endfunction

        function void note_pixel(pixel_in_t req);
            int unsigned shift;
            int unsigned tile;
            int unsigned width;
            int unsigned col;
            int unsigned rit;
            int unsigned dx;
            int unsigned oc;
            longint      px;
            longint      total;
            pixel_out_t  exp_avg;

            shift = (scale_reg > SCALE_LIMIT) ? SCALE_LIMIT : scale_reg;
            tile  = 1 << shift;
            width = width_reg;
            if (width == 0)
                width = 1;
            if (width > WIDTH_LIMIT)
                width = WIDTH_LIMIT;
            px = req.pixel_value;
            requests_seen++;

            if (req.first_of_frame)
            begin
                col_pos  = 0;
                band_row = 0;
            end
            if (col_pos >= width)
                col_pos = 0;

            col = col_pos;
            rit = band_row & (tile - 1);
            dx  = col & (tile - 1);

            if (dx == 0)
                row_acc = px;
            else
                row_acc += px;

            if (dx == tile - 1)
            begin
                if (shift == 0)
                begin
                    total = row_acc;
                end
                else
                begin
                    oc = (col >> shift) & (SUM_DEPTH - 1);
                    if (rit == 0)
                        column_totals[oc] = row_acc;
                    else
                        column_totals[oc] += row_acc;
                    total = column_totals[oc];
                end
                if (rit == tile - 1)
                begin
                    exp_avg.avg_value  = SAMPLE_BITS'(total >>> (2 * shift));
                    exp_avg.end_of_row = (col + 1 + tile > width);
                    expected_avgs      = {expected_avgs, exp_avg};
                end
            end

            if (col + 1 >= width)
            begin
                col_pos  = 0;
                band_row = (rit + 1) & (tile - 1);
            end
            else
            begin
                col_pos  = col + 1;
                band_row = rit;
            end
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t exp_avg;

            results_seen++;
            if (expected_avgs.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, actual avg_value %0d end_of_row %0b",
                         $time, got.avg_value, got.end_of_row);
                return;
            end
            exp_avg = expected_avgs.pop_front();
            if (got.avg_value !== exp_avg.avg_value)
            begin
                mismatches++;
                $display("%0t: avg_value expected %0d actual %0d",
                         $time, exp_avg.avg_value, got.avg_value);
            end
            if (got.end_of_row !== exp_avg.end_of_row)
            begin
                mismatches++;
                $display("%0t: end_of_row expected %0b actual %0b",
                         $time, exp_avg.end_of_row, got.end_of_row);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      pixel_valid = 1'b0;
    logic                      pixel_stall;
    pixel_in_t                 pixel = '0;
    logic                      avg_valid;
    logic                      avg_stall = 1'b0;
    pixel_out_t                avg;

    tile_average_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned idle_gap = 0;
    bit          hold_off_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned cycle_count = 0;
    int unsigned settings_used = 0;

    box_average_downsampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .avg_valid    (avg_valid),
        .avg_stall    (avg_stall),
        .avg          (avg)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        cycle_count++;
        if (hold_off_req)
        begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            avg_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(40, 160);
            end
            mode_left--;
            case (stall_mode)
                0:       avg_stall = 1'b0;
                1:       avg_stall = ($urandom_range(0, 3) == 0);
                2:       avg_stall = ($urandom_range(0, 3) != 0);
                default: avg_stall = cycle_count[2];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && avg_valid && !avg_stall)
            sb.check_result(avg);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int          offset;
        logic [31:0] raw;

        offset = int'($urandom_range(0, 16)) - 8;
        raw    = $urandom();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return offset[SAMPLE_BITS-1:0];
            default: return raw[SAMPLE_BITS-1:0];
        endcase
    endfunction

    task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] value, input logic fof);
        @(negedge clk);
        pixel_valid          = 1'b1;
        pixel.pixel_value    = value;
        pixel.first_of_frame = fof;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_pixel(pixel);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            repeat (idle_gap) @(negedge clk) pixel_valid = 1'b0;
            burst_left = $urandom_range(1, 40);
            idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        pixel_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic start_setting(input int unsigned scale_cfg, input int unsigned width);
        wait_idle();
        write_register(REG_SCALE_LOG2, CFG_DATA_BITS'(scale_cfg));
        write_register(REG_FULL_WIDTH, CFG_DATA_BITS'(width));
        settings_used++;
    endtask

    initial
    begin
        int unsigned scale_cfg;
        int unsigned eff_shift;
        int unsigned tile;
        int unsigned width;
        int unsigned items;
        int unsigned pick;
        int unsigned random_items;

        random_items = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // scale one, extremes pass straight through
        start_setting(0, 3);
        send_pixel(SAMPLE_MAX, 1'b1);
        send_pixel(SAMPLE_MIN, 1'b0);
        send_pixel(SAMPLE_BITS'(1), 1'b0);

        // full-scale tiles, then floor of a small negative sum
        start_setting(1, 2);
        repeat (4) send_pixel(SAMPLE_MIN, sb.col_pos == 0 && sb.band_row == 0);
        send_pixel(SAMPLE_BITS'(-1), 1'b1);
        repeat (3) send_pixel('0, 1'b0);

        // width not a multiple of the tile edge
        start_setting(1, 3);
        send_pixel(SAMPLE_MAX, 1'b1);
        repeat (5) send_pixel(SAMPLE_MAX, 1'b0);

        // scale above the maximum with zero width
        start_setting(7, 0);
        send_pixel(SAMPLE_MAX, 1'b1);
        send_pixel(SAMPLE_MIN, 1'b0);

        // zero width acts as one
        start_setting(0, 0);
        send_pixel(SAMPLE_MIN, 1'b1);
        send_pixel(SAMPLE_MAX, 1'b0);

        // width above the maximum
        start_setting(0, 16383);
        send_pixel(SAMPLE_MAX, 1'b1);
        send_pixel(SAMPLE_MIN, 1'b0);
        send_pixel(SAMPLE_BITS'(-1), 1'b0);

        // one result per request while the receiver holds off
        start_setting(0, $urandom_range(2, 40));
        hold_off_req = 1'b1;
        for (int i = 0; i < 300; i++)
            send_pixel(pick_sample(), i == 0);
        random_items += 300;

        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                scale_cfg = 0;
                width     = $urandom_range(WIDTH_LIMIT, 16383);
                items     = 24;
            end
            else if (pick < 7)
            begin
                scale_cfg = $urandom_range(0, 7);
                width     = 0;
                items     = 8;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 18)
                    scale_cfg = 0;
                else if (pick < 42)
                    scale_cfg = 1;
                else if (pick < 66)
                    scale_cfg = 2;
                else if (pick < 82)
                    scale_cfg = 3;
                else if (pick < 92)
                    scale_cfg = 4;
                else
                    scale_cfg = $urandom_range(5, 7);
                eff_shift = (scale_cfg > SCALE_LIMIT) ? SCALE_LIMIT : scale_cfg;
                tile      = 1 << eff_shift;
                if ($urandom_range(0, 5) == 0)
                    width = $urandom_range(1, 48);
                else if (tile >= 8)
                    width = tile * $urandom_range(1, 3);
                else
                    width = tile * $urandom_range(1, 12);
                items = width * tile * $urandom_range(1, 3);
                if (items > 512)
                    items = 512;
                if ($urandom_range(0, 7) == 0)
                    items = items - $urandom_range(0, items - 1);
            end
            if (items > RANDOM_ITEMS - random_items)
                items = RANDOM_ITEMS - random_items;
            start_setting(scale_cfg, width);
            for (int i = 0; i < items; i++)
                send_pixel(pick_sample(), i == 0 || $urandom_range(0, 59) == 0);
            random_items += items;
        end

        wait_idle();
        $display("Covered %0d pixel requests, %0d settings, scale_log2 0..7, width 0..16383.",
                 sb.requests_seen, settings_used);
        $display("Checked %0d tile averages, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
